// File: design/ngp_pkg.sv
// Shared types, constants and helper functions of the GGA sentence parser.
package ngp_pkg;

    localparam int MAX_SENTENCE_DEF = 128;
    localparam int FIELD_CHARS_DEF  = 10;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEN = 1'b0,
        CFG_TZ      = 1'b1
    } cfg_idx_t;

    localparam logic [6:0] MIN_LEN_RESET = 7'd30;
    localparam logic [4:0] TZ_RESET      = 5'd8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;

    localparam logic [2:0] FLD_TIME = 3'd1;
    localparam logic [2:0] FLD_LAT  = 3'd2;
    localparam logic [2:0] FLD_NS   = 3'd3;
    localparam logic [2:0] FLD_LON  = 3'd4;
    localparam logic [2:0] FLD_EW   = 3'd5;
    localparam logic [2:0] FLD_FIX  = 3'd6;
    localparam logic [2:0] FLD_LAST = 3'd7;

    localparam logic [2:0] HDR_DONE = 3'd6;

    // floor(5x/3) == (x * RECIP3_X5) >> RECIP_SHIFT for x below 2^22
    localparam logic [25:0] RECIP3_X5   = 26'd55924055;
    localparam int          RECIP_SHIFT = 25;
    localparam logic [19:0] MICRO       = 20'd1000000;
    localparam logic [29:0] LAT_MAX     = 30'd90000000;
    localparam logic [29:0] LON_MAX     = 30'd180000000;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_FIX        = 3'd1,
        ST_TOO_SHORT     = 3'd2,
        ST_NOT_GGA       = 3'd3,
        ST_FIELD_MISSING = 3'd4,
        ST_COORD_FORMAT  = 3'd5,
        ST_OUT_OF_RANGE  = 3'd6
    } status_t;

    typedef struct packed {
        logic stop;
        logic late;
        logic dot;
        logic bad;
    } cflags_t;

    typedef struct packed {
        cflags_t     f;
        logic [9:0]  deg;
        logic [19:0] mins;
    } coord_t;

    // Sentence summary handed from parser to finisher at line feed.
    typedef struct packed {
        logic            too_short;
        logic            hdr_ok;
        logic            fields_ok;
        logic            time6;
        logic [5:0][3:0] tdig;
        logic            fix;
        logic            lat_ok;
        logic            lon_ok;
        logic            south;
        logic            west;
        logic [6:0]      lat_deg;
        logic [19:0]     lat_min;
        logic [9:0]      lon_deg;
        logic [19:0]     lon_min;
    } rec_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] i);
        logic [7:0] r;
        unique case (i)
            3'd1:    r = CH_G;
            3'd2:    r = CH_P;
            3'd3:    r = CH_G;
            3'd4:    r = CH_G;
            3'd5:    r = CH_A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] frac_scale(input logic [1:0] k);
        logic [9:0] r;
        unique case (k)
            2'd0:    r = 10'd1000;
            2'd1:    r = 10'd100;
            2'd2:    r = 10'd10;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

    // One character of a ddmm.mmmm / dddmm.mmmm field; nd is the degree digit count.
    function automatic coord_t coord_step(input logic [3:0] p, input logic [1:0] nd,
                                          input logic [7:0] c, input coord_t cur);
        coord_t     r;
        logic       dig;
        logic [3:0] d;
        logic [4:0] pe;
        logic [4:0] nde;
        logic [4:0] off;
        logic [4:0] k;
        r   = cur;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d   = dig ? c[3:0] : 4'd0;
        pe  = {1'b0, p};
        nde = {3'b000, nd};
        off = cur.f.late ? 5'(nde + 5'd3) : 5'(nde + 5'd2);
        k   = 5'(pe - off);
        if (pe < nde) begin
            if (dig) r.deg = 10'(cur.deg * 10'd10 + 10'(d));
            else     r.f.bad = 1'b1;
        end else if (!cur.f.dot) begin
            if (c == CH_DOT) begin
                r.f.dot = 1'b1;
                if (pe == nde || pe > 5'(nde + 5'd2)) r.f.bad = 1'b1;
                if (pe == 5'(nde + 5'd2)) r.f.late = 1'b1;
                r.mins = 20'(cur.mins * 20'd10000);
            end else if (pe >= 5'(nde + 5'd2)) begin
                r.f.bad = 1'b1;
            end else if (dig && !cur.f.stop) begin
                r.mins = 20'(cur.mins * 20'd10 + 20'(d));
            end else begin
                r.f.stop = 1'b1;
            end
        end else if (pe >= off && k < 5'd4) begin
            if (dig && !cur.f.stop) r.mins = 20'(cur.mins + 20'(d) * 20'(frac_scale(k[1:0])));
            else                    r.f.stop = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: design/nmea_gga_position_parser.sv
// A line feed beat is registered in the queue, the products and the result before it leaves.
// Intake: one byte beat per cycle unless the queue is full; each result needs '$' and line feed.
// The front end stalls only when the two-entry record queue is full.
// Reset (aresetn, synchronous, active low) clears framing, queue and valid flags and
// restores the registers to minimum length 30 and offset 8 hours.
module nmea_gga_position_parser #(
    parameter int MAX_SENTENCE = ngp_pkg::MAX_SENTENCE_DEF,
    parameter int FIELD_CHARS  = ngp_pkg::FIELD_CHARS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic                           m_time_valid,
    output logic [6:0]                     m_utc_hour,
    output logic [6:0]                     m_utc_minute,
    output logic [6:0]                     m_utc_second,
    output logic [4:0]                     m_local_hour,
    output logic [26:0]                    m_lat_micro_deg,
    output logic                           m_lat_south,
    output logic [27:0]                    m_lon_micro_deg,
    output logic                           m_lon_west,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ngp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ngp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ngp_pkg::*;

    logic [6:0] min_len_reg;
    logic [4:0] tz_reg;
    logic       q_push, q_full, q_nempty, q_pop;
    rec_t       q_wrec, q_rrec;

    // Configuration beats are always taken; each write is registered and takes effect in the cycle after.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= MIN_LEN_RESET;
            tz_reg      <= TZ_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_LEN: min_len_reg <= cfg_data;
                CFG_TZ:      tz_reg      <= cfg_data[4:0];
                default:     ;
            endcase
        end
    end

    // Front: frame bytes, accumulate fields, push one record per line feed that ends a sentence.
    ngp_front #(
        .MAX_SENTENCE(MAX_SENTENCE),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .min_len  (min_len_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_wrec)
    );

    // Queue: decouple byte intake from result stalls.
    ngp_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wrec),
        .full   (q_full),
        .nempty (q_nempty),
        .pop    (q_pop),
        .rdata  (q_rrec)
    );

    // Back: status, time, scaled coordinates; hold the result until taken.
    ngp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tz_offset      (tz_reg),
        .q_nempty       (q_nempty),
        .q_rec          (q_rrec),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_time_valid   (m_time_valid),
        .m_utc_hour     (m_utc_hour),
        .m_utc_minute   (m_utc_minute),
        .m_utc_second   (m_utc_second),
        .m_local_hour   (m_local_hour),
        .m_lat_micro_deg(m_lat_micro_deg),
        .m_lat_south    (m_lat_south),
        .m_lon_micro_deg(m_lon_micro_deg),
        .m_lon_west     (m_lon_west)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("record pushed into full queue");

    a_range_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OK) |->
            (30'(m_lat_micro_deg) <= LAT_MAX && 30'(m_lon_micro_deg) <= LON_MAX))
        else $error("coordinate beyond range with ok status");

    a_early_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_TOO_SHORT || m_status == ST_NOT_GGA
                     || m_status == ST_FIELD_MISSING)) |->
            (!m_time_valid && m_utc_hour == 7'd0 && m_lat_micro_deg == 27'd0))
        else $error("fields not cleared on framing failure");

    a_local_hour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_local_hour < 5'd24)) else $error("local hour not reduced");

endmodule

// File: design/ngp_front.sv
// Byte front end: frames sentences and accumulates the GGA fields.
module ngp_front #(
    parameter int MAX_SENTENCE = 128,
    parameter int FIELD_CHARS  = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  logic [6:0]    min_len,
    input  logic          q_full,
    output logic          q_push,
    output ngp_pkg::rec_t q_rec
);
    import ngp_pkg::*;

    localparam int BC_W = $clog2(MAX_SENTENCE);

    logic            in_reg, in_next;
    logic [BC_W-1:0] bc_reg, bc_next;
    logic [2:0]      hm_reg, hm_next;
    logic [2:0]      fn_reg, fn_next;
    logic [3:0]      cif_reg, cif_next;
    logic [5:0][3:0] td_reg, td_next;
    coord_t          lat_reg, lat_next, lon_reg, lon_next;
    logic            t6_reg, t6_next, latlen_reg, latlen_next, lonlen_reg, lonlen_next;
    logic            south_reg, south_next, west_reg, west_next, fix_reg, fix_next;
    logic            acc;
    logic            dig;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign dig     = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);

    always_comb begin
        in_next = in_reg; bc_next = bc_reg; hm_next = hm_reg; fn_next = fn_reg;
        cif_next = cif_reg; td_next = td_reg; lat_next = lat_reg; lon_next = lon_reg;
        t6_next = t6_reg; latlen_next = latlen_reg; lonlen_next = lonlen_reg;
        south_next = south_reg; west_next = west_reg; fix_next = fix_reg;
        q_push = 1'b0;
        if (acc) begin
            if (s_rx_byte == CH_DOLLAR) begin
                in_next = 1'b1; bc_next = BC_W'(1); hm_next = 3'd1; fn_next = '0;
                cif_next = '0; td_next = '0; lat_next = '0; lon_next = '0;
                t6_next = 1'b0; latlen_next = 1'b0; lonlen_next = 1'b0;
                south_next = 1'b0; west_next = 1'b0; fix_next = 1'b0;
            end else if (in_reg) begin
                if (s_rx_byte == CH_LF) begin
                    q_push  = 1'b1;
                    in_next = 1'b0;
                end else if (bc_reg < BC_W'(MAX_SENTENCE - 1)) begin
                    bc_next = bc_reg + BC_W'(1);
                    if (bc_reg >= BC_W'(1) && bc_reg <= BC_W'(5) && hm_reg == 3'(bc_reg)
                        && s_rx_byte == hdr_char(3'(bc_reg)))
                        hm_next = hm_reg + 3'd1;
                    if (s_rx_byte == CH_COMMA) begin
                        if (fn_reg < FLD_LAST) fn_next = fn_reg + 3'd1;
                        cif_next = '0;
                    end else begin
                        if (cif_reg != 4'hF) cif_next = cif_reg + 4'd1;
                        if (32'(cif_reg) < FIELD_CHARS) begin
                            unique case (fn_reg)
                                FLD_TIME: begin
                                    if (cif_reg < 4'd6)
                                        td_next[3'(4'd5 - cif_reg)] = dig ? s_rx_byte[3:0] : 4'd0;
                                    if (cif_reg == 4'd5) t6_next = 1'b1;
                                end
                                FLD_LAT: begin
                                    lat_next = coord_step(cif_reg, 2'd2, s_rx_byte, lat_reg);
                                    if (cif_reg == 4'd4) latlen_next = 1'b1;
                                end
                                FLD_NS: if (cif_reg == 4'd0 && s_rx_byte == CH_S) south_next = 1'b1;
                                FLD_LON: begin
                                    lon_next = coord_step(cif_reg, 2'd3, s_rx_byte, lon_reg);
                                    if (cif_reg == 4'd4) lonlen_next = 1'b1;
                                end
                                FLD_EW: if (cif_reg == 4'd0 && s_rx_byte == CH_W) west_next = 1'b1;
                                FLD_FIX: if (cif_reg == 4'd0) fix_next = (s_rx_byte == CH_ONE);
                                default: ;
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        q_rec.too_short = (9'(bc_reg) < 9'(min_len));
        q_rec.hdr_ok    = (hm_reg == HDR_DONE);
        q_rec.fields_ok = (fn_reg == FLD_LAST);
        q_rec.time6     = t6_reg;
        q_rec.tdig      = td_reg;
        q_rec.fix       = fix_reg;
        q_rec.lat_ok    = latlen_reg && lat_reg.f.dot && !lat_reg.f.bad;
        q_rec.lon_ok    = lonlen_reg && lon_reg.f.dot && !lon_reg.f.bad;
        q_rec.south     = south_reg;
        q_rec.west      = west_reg;
        q_rec.lat_deg   = lat_reg.deg[6:0];
        q_rec.lat_min   = lat_reg.mins;
        q_rec.lon_deg   = lon_reg.deg;
        q_rec.lon_min   = lon_reg.mins;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg <= 1'b0; bc_reg <= '0; hm_reg <= '0; fn_reg <= '0; cif_reg <= '0;
            td_reg <= '0; lat_reg <= '0; lon_reg <= '0; t6_reg <= 1'b0;
            latlen_reg <= 1'b0; lonlen_reg <= 1'b0; south_reg <= 1'b0;
            west_reg <= 1'b0; fix_reg <= 1'b0;
        end else begin
            in_reg <= in_next; bc_reg <= bc_next; hm_reg <= hm_next; fn_reg <= fn_next;
            cif_reg <= cif_next; td_reg <= td_next; lat_reg <= lat_next; lon_reg <= lon_next;
            t6_reg <= t6_next; latlen_reg <= latlen_next; lonlen_reg <= lonlen_next;
            south_reg <= south_next; west_reg <= west_next; fix_reg <= fix_next;
        end
    end

endmodule

// File: design/ngp_queue.sv
// Short record queue between the parser and the finisher.
module ngp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ngp_pkg::rec_t wdata,
    output logic          full,
    output logic          nempty,
    input  logic          pop,
    output ngp_pkg::rec_t rdata
);
    import ngp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    rec_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full   = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign nempty = (cnt_reg != '0);
    assign rdata  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) wp_next = (32'(wp_reg) == QUEUE_DEPTH - 1) ? '0 : wp_reg + PW'(1);
        if (pop)  rp_next = (32'(rp_reg) == QUEUE_DEPTH - 1) ? '0 : rp_reg + PW'(1);
        if (push && !pop)      cnt_next = cnt_reg + (PW+1)'(1);
        else if (!push && pop) cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: design/ngp_back.sv
// Back end: status priority, time fields, coordinate scaling and range check.
module ngp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [4:0]    tz_offset,
    input  logic          q_nempty,
    input  ngp_pkg::rec_t q_rec,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic          m_time_valid,
    output logic [6:0]    m_utc_hour,
    output logic [6:0]    m_utc_minute,
    output logic [6:0]    m_utc_second,
    output logic [4:0]    m_local_hour,
    output logic [26:0]   m_lat_micro_deg,
    output logic          m_lat_south,
    output logic [27:0]   m_lon_micro_deg,
    output logic          m_lon_west
);
    import ngp_pkg::*;

    // stage 1: products
    logic        s1_valid_reg;
    status_t     s1_st_reg, s1_st_next;
    logic        s1_tv_reg, s1_tv_next;
    logic [6:0]  s1_h_reg, s1_h_next, s1_m_reg, s1_m_next, s1_s_reg, s1_s_next;
    logic [26:0] s1_latd_reg, s1_latd_next;
    logic [29:0] s1_lond_reg, s1_lond_next;
    logic [20:0] s1_latq_reg, s1_latq_next, s1_lonq_reg, s1_lonq_next;
    logic        s1_south_reg, s1_west_reg;
    logic [45:0] lat_prod, lon_prod;

    // stage 2: result register
    logic        out_valid_reg;
    logic [29:0] lat_sum, lon_sum;
    logic [7:0]  hsum, hr1, hr2, hr3;
    status_t     st_fin;

    logic out_free, s1_adv, s1_load;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s1_load  = q_nempty && (!s1_valid_reg || s1_adv);
    assign q_pop    = s1_load;
    assign m_valid  = out_valid_reg;

    always_comb begin
        priority if (q_rec.too_short)            s1_st_next = ST_TOO_SHORT;
        else if (!q_rec.hdr_ok)                  s1_st_next = ST_NOT_GGA;
        else if (!q_rec.fields_ok)               s1_st_next = ST_FIELD_MISSING;
        else if (!q_rec.fix)                     s1_st_next = ST_NO_FIX;
        else if (!(q_rec.lat_ok && q_rec.lon_ok)) s1_st_next = ST_COORD_FORMAT;
        else                                     s1_st_next = ST_OK;
        s1_tv_next = q_rec.time6 && !q_rec.too_short && q_rec.hdr_ok && q_rec.fields_ok;
        s1_h_next  = 7'(q_rec.tdig[5] * 7'd10 + 7'(q_rec.tdig[4]));
        s1_m_next  = 7'(q_rec.tdig[3] * 7'd10 + 7'(q_rec.tdig[2]));
        s1_s_next  = 7'(q_rec.tdig[1] * 7'd10 + 7'(q_rec.tdig[0]));
        s1_latd_next = 27'(27'(q_rec.lat_deg) * 27'(MICRO));
        s1_lond_next = 30'(q_rec.lon_deg) * 30'(MICRO);
        // (minutes * 5) / 3 via reciprocal multiply
        lat_prod     = 46'(q_rec.lat_min) * 46'(RECIP3_X5);
        lon_prod     = 46'(q_rec.lon_min) * 46'(RECIP3_X5);
        s1_latq_next = lat_prod[RECIP_SHIFT +: 21];
        s1_lonq_next = lon_prod[RECIP_SHIFT +: 21];
    end

    always_comb begin
        lat_sum = 30'(s1_latd_reg) + 30'(s1_latq_reg);
        lon_sum = s1_lond_reg + 30'(s1_lonq_reg);
        st_fin  = s1_st_reg;
        if (s1_st_reg == ST_OK && (lat_sum > LAT_MAX || lon_sum > LON_MAX))
            st_fin = ST_OUT_OF_RANGE;
        // hour sum is below 192: reduce modulo 24 in three steps
        hsum = 8'(s1_h_reg) + 8'(tz_offset);
        hr1  = (hsum >= 8'd96) ? hsum - 8'd96 : hsum;
        hr2  = (hr1 >= 8'd48) ? hr1 - 8'd48 : hr1;
        hr3  = (hr2 >= 8'd24) ? hr2 - 8'd24 : hr2;
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_st_reg <= s1_st_next; s1_tv_reg <= s1_tv_next;
            s1_h_reg <= s1_h_next; s1_m_reg <= s1_m_next; s1_s_reg <= s1_s_next;
            s1_latd_reg <= s1_latd_next; s1_lond_reg <= s1_lond_next;
            s1_latq_reg <= s1_latq_next; s1_lonq_reg <= s1_lonq_next;
            s1_south_reg <= q_rec.south; s1_west_reg <= q_rec.west;
        end
        if (s1_adv) begin
            m_status        <= st_fin;
            m_time_valid    <= s1_tv_reg;
            m_utc_hour      <= s1_tv_reg ? s1_h_reg : 7'd0;
            m_utc_minute    <= s1_tv_reg ? s1_m_reg : 7'd0;
            m_utc_second    <= s1_tv_reg ? s1_s_reg : 7'd0;
            m_local_hour    <= s1_tv_reg ? hr3[4:0] : 5'd0;
            m_lat_micro_deg <= (st_fin == ST_OK) ? lat_sum[26:0] : 27'd0;
            m_lon_micro_deg <= (st_fin == ST_OK) ? lon_sum[27:0] : 28'd0;
            m_lat_south     <= (st_fin == ST_OK) && s1_south_reg;
            m_lon_west      <= (st_fin == ST_OK) && s1_west_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_load)     s1_valid_reg <= 1'b1;
            else if (s1_adv) s1_valid_reg <= 1'b0;
            if (s1_adv)       out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

endmodule
